>>> hw/rtl/svs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svs_pkg;

   localparam int NUM_SERVOS = 8;
   localparam int CH_W       = 3;

   localparam logic [15:0] DEFAULT_MIN_PULSE = 16'd544;
   localparam logic [15:0] DEFAULT_MAX_PULSE = 16'd2400;
   localparam logic [15:0] SPEED_RESET       = 16'hffff;
   localparam logic [16:0] FULL_SCALE        = 17'd65535;

   localparam logic [1:0] CMD_FRAME  = 2'd0;
   localparam logic [1:0] CMD_TARGET = 2'd1;
   localparam logic [1:0] CMD_SPEED  = 2'd2;
   localparam logic [1:0] CMD_RANGE  = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = 2;

   typedef enum logic [1:0] {
      OP_FRAME,
      OP_TARGET,
      OP_SPEED,
      OP_RANGE
   } op_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  channel;
      logic [15:0] data_word;
      logic [15:0] data_word_high;
      logic [7:0]  elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_channel;
      logic [15:0] pulse_width;
      logic [15:0] angle_now;
      logic        target_reached;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type          op;
      logic [CH_W-1:0] channel;
      logic [15:0]     data_word;
      logic [15:0]     data_word_high;
      logic [7:0]      elapsed_ms;
   } job_type;

endpackage

`default_nettype wire

>>> hw/rtl/multi_servo_slew_pulse_update.sv
// Eight-channel servo slew limiter. Set-target, set-speed and set-range commands
// are applied as they leave the queue and give no result. A frame tick leaves the
// queue and then walks the channels in order, one per cycle, holding the back end
// until the last channel is issued; each result passes the stage 1-3 and rsp registers
// and shows on rsp_valid for a single cycle, with last set on the final channel.
// Commands wait in a 4-entry queue and busy rises only when that queue is full.
// Results cannot be held off: take each one in the cycle rsp_valid is high.
`timescale 1ns / 1ps
`default_nettype none

module multi_servo_slew_pulse_update import svs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req,
   output logic         rsp_valid,
   output rsp_type      rsp
);

   logic    push, pop, q_empty, q_full;
   job_type job_in, job_out;

   svs_front u_front (
      .start      (start),
      .req        (req),
      .queue_full (q_full),
      .busy       (busy),
      .push       (push),
      .job        (job_in)
   );

   svs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (job_in),
      .pop     (pop),
      .job_out (job_out),
      .empty   (q_empty),
      .full    (q_full)
   );

   svs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_out),
      .empty     (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

>>> hw/rtl/svs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module svs_front import svs_pkg::*; (
   input  wire logic    start,
   input  wire req_type req,
   input  wire logic    queue_full,
   output logic         busy,
   output logic         push,
   output job_type      job
);

   op_type op;
   logic   ch_ok;

   always_comb begin
      unique case (req.cmd)
         CMD_FRAME:  op = OP_FRAME;
         CMD_TARGET: op = OP_TARGET;
         CMD_SPEED:  op = OP_SPEED;
         CMD_RANGE:  op = OP_RANGE;
         default:    op = OP_FRAME;
      endcase
   end

   // drop writes to channels that do not exist
   assign ch_ok = (int'(req.channel) < NUM_SERVOS);

   assign busy = queue_full;
   assign push = start && !queue_full && ((op == OP_FRAME) || ch_ok);

   always_comb begin
      job.op             = op;
      job.channel        = CH_W'(req.channel);
      job.data_word      = req.data_word;
      job.data_word_high = req.data_word_high;
      job.elapsed_ms     = req.elapsed_ms;
   end

endmodule

`default_nettype wire

>>> hw/rtl/svs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module svs_queue import svs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type job_in,
   input  wire logic    pop,
   output job_type      job_out,
   output logic         empty,
   output logic         full
);

   job_type              mem_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (Q_PTR_W + 1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign job_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/svs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module svs_back import svs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type job,
   input  wire logic    empty,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_type      rsp
);

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   state_type       state_ff;
   logic [CH_W-1:0] cnt_ff;
   logic [7:0]      elapsed_ff;

   logic [15:0] angle_ff  [NUM_SERVOS];
   logic [15:0] target_ff [NUM_SERVOS];
   logic [15:0] speed_ff  [NUM_SERVOS];
   logic [15:0] lo_ff     [NUM_SERVOS];
   logic [15:0] hi_ff     [NUM_SERVOS];

   // stage 1: fetch and step size
   logic            s1_valid_ff, s1_last_ff;
   logic [CH_W-1:0] s1_ch_ff;
   logic [15:0]     s1_angle_ff, s1_target_ff, s1_lo_ff, s1_hi_ff;
   logic [23:0]     s1_step_ff, s1_step_in;

   // stage 2: new angle
   logic            s2_valid_ff, s2_last_ff, s2_reached_ff, s2_neg_ff;
   logic [CH_W-1:0] s2_ch_ff;
   logic [15:0]     s2_pos_ff, s2_lo_ff, s2_span_ff;
   logic [15:0]     gap, pos_in, span_in;
   logic            neg_in;

   // stage 3: scaled product
   logic            s3_valid_ff, s3_last_ff, s3_reached_ff, s3_neg_ff;
   logic [CH_W-1:0] s3_ch_ff;
   logic [15:0]     s3_pos_ff, s3_lo_ff;
   logic [31:0]     s3_prod_ff;

   // stage 4: divide by full scale and offset
   logic [15:0]     q_est, quot, pulse_in;
   logic [16:0]     rem_est;

   logic            issue;

   assign pop   = (state_ff == ST_IDLE) && !empty;
   assign issue = (state_ff == ST_SWEEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         elapsed_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (pop && (job.op == OP_FRAME)) begin
                  state_ff   <= ST_SWEEP;
                  cnt_ff     <= '0;
                  elapsed_ff <= job.elapsed_ms;
               end
            end
            ST_SWEEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CH_W'(NUM_SERVOS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // channel settings
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SERVOS; i++) begin
            target_ff[i] <= '0;
            speed_ff[i]  <= SPEED_RESET;
            lo_ff[i]     <= DEFAULT_MIN_PULSE;
            hi_ff[i]     <= DEFAULT_MAX_PULSE;
         end
      end else if (pop) begin
         unique case (job.op)
            OP_TARGET: target_ff[job.channel] <= job.data_word;
            OP_SPEED:  speed_ff[job.channel]  <= job.data_word;
            OP_RANGE: begin
               lo_ff[job.channel] <= job.data_word;
               hi_ff[job.channel] <= job.data_word_high;
            end
            OP_FRAME: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SERVOS; i++) begin
            angle_ff[i] <= '0;
         end
      end else if (s2_valid_ff) begin
         angle_ff[s2_ch_ff] <= s2_pos_ff;
      end
   end

   assign s1_step_in = 24'(speed_ff[cnt_ff]) * 24'(elapsed_ff);

   always_comb begin
      gap     = (s1_target_ff > s1_angle_ff) ? s1_target_ff - s1_angle_ff
                                             : s1_angle_ff - s1_target_ff;
      // limit the step so the angle never passes the target
      if (s1_step_ff >= 24'(gap)) begin
         pos_in = s1_target_ff;
      end else if (s1_target_ff < s1_angle_ff) begin
         pos_in = s1_angle_ff - s1_step_ff[15:0];
      end else begin
         pos_in = s1_angle_ff + s1_step_ff[15:0];
      end
      neg_in  = (s1_hi_ff < s1_lo_ff);
      span_in = neg_in ? s1_lo_ff - s1_hi_ff : s1_hi_ff - s1_lo_ff;
   end

   // x / 65535 for x up to 65535 * 65535: estimate with x >> 16, correct once
   always_comb begin
      q_est    = s3_prod_ff[31:16];
      rem_est  = 17'(s3_prod_ff[15:0]) + 17'(q_est);
      quot     = (rem_est >= FULL_SCALE) ? q_est + 16'd1 : q_est;
      pulse_in = s3_neg_ff ? s3_lo_ff - quot : s3_lo_ff + quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         rsp_valid   <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ch_ff     <= cnt_ff;
      s1_last_ff   <= (cnt_ff == CH_W'(NUM_SERVOS - 1));
      s1_angle_ff  <= angle_ff[cnt_ff];
      s1_target_ff <= target_ff[cnt_ff];
      s1_lo_ff     <= lo_ff[cnt_ff];
      s1_hi_ff     <= hi_ff[cnt_ff];
      s1_step_ff   <= s1_step_in;

      s2_ch_ff      <= s1_ch_ff;
      s2_last_ff    <= s1_last_ff;
      s2_pos_ff     <= pos_in;
      s2_reached_ff <= (pos_in == s1_target_ff);
      s2_lo_ff      <= s1_lo_ff;
      s2_neg_ff     <= neg_in;
      s2_span_ff    <= span_in;

      s3_ch_ff      <= s2_ch_ff;
      s3_last_ff    <= s2_last_ff;
      s3_pos_ff     <= s2_pos_ff;
      s3_reached_ff <= s2_reached_ff;
      s3_lo_ff      <= s2_lo_ff;
      s3_neg_ff     <= s2_neg_ff;
      s3_prod_ff    <= 32'(s2_pos_ff) * 32'(s2_span_ff);

      rsp.out_channel    <= 3'(s3_ch_ff);
      rsp.pulse_width    <= pulse_in;
      rsp.angle_now      <= s3_pos_ff;
      rsp.target_reached <= s3_reached_ff;
      rsp.last           <= s3_last_ff;
   end

endmodule

`default_nettype wire
